// ===== hw/rtl/pcma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcma_pkg
// Shared types and constants for the per-channel moving average block.
// ----------------------------------------------------------------------------
package pcma_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int CHANNELS     = 2;
    localparam int CHANNEL_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] channel;
        logic [SAMPLE_BITS-1:0]  sample;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic                   window_full;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIVIDE,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture the accepted request
        logic mem_rd;    // read the oldest window entry
        logic update;    // write window, update sum/position, load divider
        logic div_step;  // one quotient bit
        logic out_load;  // move quotient into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_last;
    } t_dp_sts;

endpackage : pcma_pkg
`default_nettype wire

// ===== hw/rtl/pcma_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcma_ctrl
// Sequencer: accept a request, read the window, update, divide, hand off.
// ----------------------------------------------------------------------------
module pcma_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    input  pcma_pkg::t_dp_sts i_sts,
    output pcma_pkg::t_dp_cmd o_cmd
);

    pcma_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcma_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcma_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pcma_pkg::S_READ;
            end
            pcma_pkg::S_READ:   n_state = pcma_pkg::S_UPDATE;
            pcma_pkg::S_UPDATE: n_state = pcma_pkg::S_DIVIDE;
            pcma_pkg::S_DIVIDE: begin
                if (i_sts.div_last) n_state = pcma_pkg::S_DONE;
            end
            pcma_pkg::S_DONE: begin
                if (out_free) n_state = pcma_pkg::S_IDLE;
            end
            default: n_state = pcma_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            pcma_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.latch = i_in_valid;
            end
            pcma_pkg::S_READ:   o_cmd.mem_rd   = 1'b1;
            pcma_pkg::S_UPDATE: o_cmd.update   = 1'b1;
            pcma_pkg::S_DIVIDE: o_cmd.div_step = 1'b1;
            pcma_pkg::S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule : pcma_ctrl
`default_nettype wire

// ===== hw/rtl/pcma_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcma_datapath
// Window memory, per-channel sums and positions, bit-serial divider.
// ----------------------------------------------------------------------------
module pcma_datapath #(
    parameter int WINDOW_SIZE = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pcma_pkg::t_dp_cmd   i_cmd,
    output pcma_pkg::t_dp_sts   o_sts,
    input  pcma_pkg::t_in_item  i_in_data,
    output pcma_pkg::t_out_item o_out_data
);

    localparam int CHANNELS  = pcma_pkg::CHANNELS;
    localparam int SB        = pcma_pkg::SAMPLE_BITS;
    localparam int PW        = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW        = $clog2(WINDOW_SIZE + 1);
    localparam int SW        = SB + CW;
    localparam int CHW       = pcma_pkg::CHANNEL_BITS;
    localparam int AW        = CHW + PW;
    localparam int MEM_DEPTH = CHANNELS * (1 << PW);
    localparam int KW        = (SW > 1) ? $clog2(SW) : 1;

    // window store; an entry past the write position is unwritten until full
    logic [SB-1:0]  mem [0:MEM_DEPTH-1];
    logic [SB-1:0]  r_rd_data;

    logic [SW-1:0]  r_sum  [0:CHANNELS-1];
    logic [PW-1:0]  r_pos  [0:CHANNELS-1];
    logic           r_full [0:CHANNELS-1];

    logic [CHW-1:0] r_ch;
    logic [SB-1:0]  r_smp;

    logic [SW-1:0]  r_dividend;
    logic [CW-1:0]  r_rem;
    logic [CW-1:0]  r_divisor;
    logic [SW-1:0]  r_quo;
    logic [KW-1:0]  r_cnt;
    logic           r_res_full;

    pcma_pkg::t_out_item r_out;

    logic [CHW-1:0] in_ch;
    logic [AW-1:0]  addr;
    logic [SB-1:0]  old_smp;
    logic [SW-1:0]  sum_new;
    logic [PW-1:0]  pos_next;
    logic           full_new;
    logic [CW-1:0]  count;
    logic [CW:0]    trial;
    logic           q_bit;

    // a single-channel build ignores the channel field
    assign in_ch = (CHANNELS == 1) ? '0 : i_in_data.channel;

    assign addr     = {r_ch, r_pos[r_ch]};
    assign old_smp  = r_full[r_ch] ? r_rd_data : '0;
    assign sum_new  = r_sum[r_ch] - SW'(old_smp) + SW'(r_smp);
    assign pos_next = (r_pos[r_ch] == PW'(WINDOW_SIZE - 1)) ? '0 : r_pos[r_ch] + 1'b1;
    assign full_new = r_full[r_ch] || (pos_next == '0);
    assign count    = full_new ? CW'(WINDOW_SIZE) : CW'(pos_next);

    assign trial = {r_rem, r_dividend[SW-1]};
    assign q_bit = (trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) mem[addr] <= r_smp;
        if (i_cmd.mem_rd) r_rd_data <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c]  <= '0;
                r_pos[c]  <= '0;
                r_full[c] <= 1'b0;
            end
        end else if (i_cmd.update) begin
            r_sum[r_ch]  <= sum_new;
            r_pos[r_ch]  <= pos_next;
            r_full[r_ch] <= full_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_ch  <= in_ch;
            r_smp <= i_in_data.sample;
        end
        if (i_cmd.update) begin
            r_dividend <= sum_new;
            r_rem      <= '0;
            r_divisor  <= count;
            r_quo      <= '0;
            r_cnt      <= KW'(SW - 1);
            r_res_full <= full_new;
        end else if (i_cmd.div_step) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= q_bit ? CW'(trial - {1'b0, r_divisor}) : CW'(trial);
            r_quo      <= {r_quo[SW-2:0], q_bit};
            r_cnt      <= r_cnt - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.average     <= r_quo[SB-1:0];
            r_out.window_full <= r_res_full;
        end
    end

    assign o_sts.div_last = (r_cnt == '0);
    assign o_out_data     = r_out;

endmodule : pcma_datapath
`default_nettype wire

// ===== hw/rtl/per_channel_moving_average.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_channel_moving_average
// Boxcar moving average with an independent window for each channel.
//
// Input channel: i_in_valid / o_in_stall carry one request (channel number,
// unsigned ADC sample). Output channel: o_out_valid / i_out_stall carry the
// truncated mean of that channel's window and its window-full flag.
// One request is in flight at a time. From acceptance to the result in the
// output register it goes through one read of the window memory, one
// update, then the restoring divider that produces one quotient bit a
// cycle. The next request can be taken in the cycle after the hand-off.
// Reset (synchronous, active low) clears every sum, position and full flag
// but not the window memory; unwritten window entries read as zero through
// the full flag. When the receiver stalls, the result holds in the output
// register and the next request is still accepted and processed; it waits
// at the end of the divide until the output register frees up.
// ----------------------------------------------------------------------------
module per_channel_moving_average #(
    parameter int WINDOW_SIZE = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  pcma_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output pcma_pkg::t_out_item o_out_data
);

    pcma_pkg::t_dp_cmd cmd;
    pcma_pkg::t_dp_sts sts;

    pcma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pcma_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule : per_channel_moving_average
`default_nettype wire

// ===== tb/sv/per_channel_moving_average_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_channel_moving_average_tb
// Self-checking bench for the per-channel moving average. Requests are sent
// in random bursts, or back to back, while the sink stalls on its own
// pattern. Each accepted request is run through a local window/sum model.
// Every result is compared in order against the model's prediction.
// ----------------------------------------------------------------------------
module per_channel_moving_average_tb;

    localparam int SAMPLE_BITS = pcma_pkg::SAMPLE_BITS;
    localparam int WINDOW_SIZE = 8;
    localparam int CHANNELS    = pcma_pkg::CHANNELS;
    localparam int SUM_BITS    = 15;
    localparam int DRAIN_WAIT  = 64;
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam int SINK_OPEN   = 0;
    localparam int SINK_RANDOM = 1;
    localparam int SINK_BURSTY = 2;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    pcma_pkg::t_in_item  in_data   = '0;
    logic                out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    pcma_pkg::t_out_item o_out_data;

    // local copy of the filter state
    logic [SAMPLE_BITS-1:0] win_store [CHANNELS][WINDOW_SIZE];
    logic [SUM_BITS-1:0]    win_sum   [CHANNELS];
    int unsigned            win_pos   [CHANNELS];
    logic                   win_full  [CHANNELS];

    pcma_pkg::t_out_item expected_averages[$];
    int unsigned mismatch_count  = 0;
    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned full_results    = 0;
    int unsigned chan_requests [CHANNELS];
    int unsigned burst_left      = 0;
    bit          gaps_on         = 1'b1;

    per_channel_moving_average #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_windows();
        for (int c = 0; c < CHANNELS; c++) begin
            for (int w = 0; w < WINDOW_SIZE; w++) begin
                win_store[c][w] = '0;
            end
            win_sum[c]       = '0;
            win_pos[c]       = 0;
            win_full[c]      = 1'b0;
            chan_requests[c] = 0;
        end
    endfunction

    function automatic pcma_pkg::t_out_item predict_average(input pcma_pkg::t_in_item req);
        int unsigned         ch;
        int unsigned         pos;
        int unsigned         fill;
        pcma_pkg::t_out_item res;
        ch  = req.channel % CHANNELS;
        pos = win_pos[ch];
        // drop the oldest sample, add the new one
        win_sum[ch]        = win_sum[ch] - win_store[ch][pos] + req.sample;
        win_store[ch][pos] = req.sample;
        pos                = (pos + 1) % WINDOW_SIZE;
        win_pos[ch]        = pos;
        if (pos == 0) begin
            win_full[ch] = 1'b1;
        end
        fill = win_full[ch] ? WINDOW_SIZE : pos;
        res.average     = SAMPLE_BITS'(int'(win_sum[ch]) / fill);
        res.window_full = win_full[ch];
        return res;
    endfunction

    task automatic send_request(input logic ch, input logic [SAMPLE_BITS-1:0] smp);
        pcma_pkg::t_in_item req;
        req.channel = ch;
        req.sample  = smp;
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left != 0) begin
            burst_left--;
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        expected_averages.push_back(predict_average(req));
        requests_sent++;
        chan_requests[req.channel % CHANNELS]++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        stop_sending();
        while (expected_averages.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // maximum-value fill on one channel, then overwrite the oldest entries
    task automatic test_fill_at_max_sample();
        gaps_on = 1'b0;
        repeat (WINDOW_SIZE) send_request(1'b0, SAMPLE_MAX);
        repeat (2) send_request(1'b0, '0);
    endtask

    // other channel fills with bit patterns, interleaved with channel 0 requests that continue its own window
    task automatic test_channel_isolation();
        gaps_on = 1'b1;
        send_request(1'b1, '0);
        send_request(1'b1, 12'h001);
        send_request(1'b0, 12'h001);
        send_request(1'b1, 12'h800);
        send_request(1'b1, 12'hAAA);
        send_request(1'b1, 12'h555);
        send_request(1'b0, 12'hFFE);
        send_request(1'b1, 12'h7FF);
        send_request(1'b1, SAMPLE_MAX);
        send_request(1'b1, SAMPLE_MAX);
    endtask

    task automatic test_random_traffic(input int unsigned n_requests, input bit with_gaps);
        int unsigned            run_left;
        logic                   ch;
        logic [SAMPLE_BITS-1:0] smp;
        gaps_on  = with_gaps;
        run_left = 0;
        ch       = 1'b0;
        for (int unsigned k = 0; k < n_requests; k++) begin
            // channel runs of random length, so windows wrap often
            if (run_left == 0) begin
                ch       = 1'($urandom_range(0, 1));
                run_left = $urandom_range(1, 20);
            end
            run_left--;
            case ($urandom_range(0, 7))
                0:       smp = '0;
                1:       smp = SAMPLE_MAX;
                2:       smp = SAMPLE_BITS'($urandom_range(0, 15));
                default: smp = SAMPLE_BITS'($urandom_range(0, 4095));
            endcase
            send_request(ch, smp);
        end
    endtask

    // sender holds off until the block has nothing left in flight
    task automatic test_pause_until_drained();
        wait_until_drained();
        gaps_on = 1'b1;
        repeat (4) send_request(1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom_range(0, 4095)));
    endtask

    always @(posedge i_clk) begin
        pcma_pkg::t_out_item exp_res;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_averages.size() == 0) begin
                $error("result with no request pending: average %0d window_full %0d",
                       o_out_data.average, o_out_data.window_full);
                mismatch_count++;
            end else begin
                exp_res = expected_averages.pop_front();
                results_checked++;
                if (exp_res.window_full) begin
                    full_results++;
                end
                if (o_out_data.average !== exp_res.average) begin
                    $error("average: expected %0d, got %0d",
                           exp_res.average, o_out_data.average);
                    mismatch_count++;
                end
                if (o_out_data.window_full !== exp_res.window_full) begin
                    $error("window_full: expected %0d, got %0d",
                           exp_res.window_full, o_out_data.window_full);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : sink_pattern
        int   mode;
        int   hold;
        logic stalled;
        stalled = 1'b0;
        hold    = 0;
        forever begin
            mode = $urandom_range(SINK_OPEN, SINK_BURSTY);
            repeat ($urandom_range(100, 600)) begin
                @(negedge i_clk);
                case (mode)
                    SINK_OPEN: begin
                        stalled = 1'b0;
                    end
                    SINK_RANDOM: begin
                        stalled = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        if (hold == 0) begin
                            stalled = !stalled;
                            hold    = stalled ? $urandom_range(1, 40) : $urandom_range(1, 8);
                        end
                        hold--;
                    end
                endcase
                out_stall <= stalled;
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        clear_windows();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_at_max_sample();
        test_channel_isolation();
        test_random_traffic(700, 1'b1);
        test_pause_until_drained();
        test_random_traffic(400, 1'b0);
        test_random_traffic(900, 1'b1);

        wait_until_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d requests (channel 0: %0d, channel 1: %0d), checked %0d results",
                 requests_sent, chan_requests[0], chan_requests[1], results_checked);
        $display("%0d results with a full window, %0d mismatches",
                 full_results, mismatch_count);
        if (mismatch_count == 0 && expected_averages.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
